// ===== rtl/fas_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame animation sequencer package
// Shared types and constants for the sequencer and its frame table RAM.
// ----------------------------------------------------------------------------
package fas_pkg;

   // Request selector codes.
   localparam logic [1:0] REQ_LOAD    = 2'd0;
   localparam logic [1:0] REQ_TICK    = 2'd1;
   localparam logic [1:0] REQ_RESTART = 2'd2;
   localparam logic [1:0] REQ_NOP     = 2'd3;

   // Fixed field widths.
   localparam int TEX_W   = 16;
   localparam int HOLD_W  = 16;
   localparam int RND_W   = 16;
   localparam int LOOP_W  = 8;
   localparam int DIVC_W  = $clog2(RND_W);

   // One frame as stored in the table.
   typedef struct packed {
      logic [TEX_W-1:0]  texture;
      logic [HOLD_W-1:0] dmin;
      logic [HOLD_W-1:0] dmax;
   } frame_entry_type;

endpackage

// ===== rtl/frame_animation_sequencer.sv =====
// ----------------------------------------------------------------------------
// Frame animation sequencer
// Plays back a table of animation frames with randomized hold times.
// ----------------------------------------------------------------------------
// Each request beat is captured in the idle state and handled in the
// execute state; an item that reads the frame table passes the read state,
// and one that draws a randomized delay then runs the one-bit-per-cycle
// remainder unit. The result waits in the done state until the output
// register is free. One item is processed at a time. Reset clears all control
// state and the loop count register; the frame table itself is not cleared.
// ----------------------------------------------------------------------------
module frame_animation_sequencer
   import fas_pkg::*;
#(
   parameter int MAX_FRAMES = 16,
   parameter int DELAY_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   // Request channel.
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_type,
   input  logic [TEX_W-1:0]    req_frame_texture,
   input  logic [HOLD_W-1:0]   req_frame_delay_min,
   input  logic [HOLD_W-1:0]   req_frame_delay_max,
   input  logic [RND_W-1:0]    req_random_value,
   // Response channel.
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [TEX_W-1:0]    rsp_texture_out,
   output logic                rsp_no_frames,
   output logic                rsp_done_res,
   output logic                rsp_load_error,
   // Loop count register.
   input  logic                csr_wr_en,
   input  logic [LOOP_W-1:0]   csr_wr_data
);

   // Table address and fill count widths follow from the table depth.
   localparam int ADDR_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W  = $clog2(MAX_FRAMES + 1);

   // Sequencer states.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   // A drawn delay is at most 17 bits wide; it is cut or widened to the
   // timer width here.
   function automatic logic [DELAY_BITS-1:0] fit_delay(input logic [HOLD_W:0] v);
      logic [HOLD_W+32:0] ext;
      ext = {32'd0, v};
      return ext[DELAY_BITS-1:0];
   endfunction

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   logic [2:0]            state_ff,     state_in;
   logic [1:0]            rq_type_ff,   rq_type_in;
   logic [TEX_W-1:0]      rq_tex_ff,    rq_tex_in;
   logic [HOLD_W-1:0]     rq_min_ff,    rq_min_in;
   logic [HOLD_W-1:0]     rq_max_ff,    rq_max_in;
   logic [RND_W-1:0]      rq_rnd_ff,    rq_rnd_in;
   logic [LOOP_W-1:0]     loop_count_ff, loop_count_in;
   logic [CNT_W-1:0]      loaded_ff,    loaded_in;
   logic [ADDR_W-1:0]     ptr_ff,       ptr_in;
   logic [DELAY_BITS-1:0] timer_ff,     timer_in;
   logic [DELAY_BITS-1:0] delay_ff,     delay_in;
   logic [LOOP_W-1:0]     loops_ff,     loops_in;
   logic                  finished_ff,  finished_in;
   logic                  need_draw_ff, need_draw_in;
   logic [TEX_W-1:0]      res_tex_ff,   res_tex_in;
   logic                  res_nof_ff,   res_nof_in;
   logic                  res_lerr_ff,  res_lerr_in;
   logic [HOLD_W:0]       div_rem_ff,   div_rem_in;
   logic [HOLD_W:0]       div_den_ff,   div_den_in;
   logic [HOLD_W-1:0]     div_lo_ff,    div_lo_in;
   logic [DIVC_W-1:0]     div_cnt_ff,   div_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TEX_W-1:0]      rsp_tex_ff,   rsp_tex_in;
   logic                  rsp_nof_ff,   rsp_nof_in;
   logic                  rsp_done_ff,  rsp_done_in;
   logic                  rsp_lerr_ff,  rsp_lerr_in;

   // ------------------------------------------------------------------------
   // Frame table RAM. A load writes its entry in the execute cycle, and any
   // later read belongs to a later request, so reads and writes of the same
   // entry never overlap and no forwarding is needed.
   // ------------------------------------------------------------------------
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [ADDR_W-1:0]     ram_rd_addr;
   frame_entry_type       ram_wr_data;
   frame_entry_type       ram_rd_data;

   assign ram_wr_data = '{texture: rq_tex_ff, dmin: rq_min_ff, dmax: rq_max_ff};

   fas_ram #(
      .WIDTH ($bits(frame_entry_type)),
      .DEPTH (MAX_FRAMES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (loaded_ff[ADDR_W-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------------
   // Tick arithmetic, evaluated in the execute cycle. The timer saturates,
   // the loop counter saturates, and a wrap past the last loaded frame counts
   // one loop only while a loop limit is set.
   // ------------------------------------------------------------------------
   logic [DELAY_BITS-1:0] timer_inc;
   logic                  step;
   logic [CNT_W-1:0]      next_cnt;
   logic                  wrap;
   logic [ADDR_W-1:0]     ptr_next;
   logic [LOOP_W-1:0]     loops_inc;
   logic                  fin_now;
   logic                  table_full;

   assign timer_inc  = (timer_ff != '1) ? timer_ff + 1'b1 : timer_ff;
   assign step       = (timer_inc >= delay_ff);
   assign next_cnt   = CNT_W'(ptr_ff) + 1'b1;
   assign wrap       = (next_cnt >= loaded_ff);
   assign ptr_next   = wrap ? '0 : next_cnt[ADDR_W-1:0];
   assign loops_inc  = (loops_ff != '1) ? loops_ff + 1'b1 : loops_ff;
   assign fin_now    = wrap && (loop_count_ff != '0) && (loops_inc >= loop_count_ff);
   assign table_full = (loaded_ff >= CNT_W'(MAX_FRAMES));

   // One restoring remainder step: shift in the next random bit and subtract
   // the span when it fits. The partial remainder stays below the span, so
   // the difference always fits the remainder register.
   logic [HOLD_W+1:0]     div_shift;
   logic [HOLD_W+1:0]     div_diff;
   logic [HOLD_W:0]       div_next;

   assign div_shift = {div_rem_ff, rq_rnd_ff[RND_W-1]};
   assign div_diff  = div_shift - {1'b0, div_den_ff};
   assign div_next  = (div_shift >= {1'b0, div_den_ff})
                      ? div_diff[HOLD_W:0] : div_shift[HOLD_W:0];

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      rq_type_in    = rq_type_ff;
      rq_tex_in     = rq_tex_ff;
      rq_min_in     = rq_min_ff;
      rq_max_in     = rq_max_ff;
      rq_rnd_in     = rq_rnd_ff;
      loop_count_in = csr_wr_en ? csr_wr_data : loop_count_ff;
      loaded_in     = loaded_ff;
      ptr_in        = ptr_ff;
      timer_in      = timer_ff;
      delay_in      = delay_ff;
      loops_in      = loops_ff;
      finished_in   = finished_ff;
      need_draw_in  = need_draw_ff;
      res_tex_in    = res_tex_ff;
      res_nof_in    = res_nof_ff;
      res_lerr_in   = res_lerr_ff;
      div_rem_in    = div_rem_ff;
      div_den_in    = div_den_ff;
      div_lo_in     = div_lo_ff;
      div_cnt_in    = div_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_tex_in    = rsp_tex_ff;
      rsp_nof_in    = rsp_nof_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_lerr_in   = rsp_lerr_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = ptr_ff;

      unique case (state_ff)
         S_IDLE: begin
            // Capture the request beat.
            if (req_valid) begin
               rq_type_in = req_type;
               rq_tex_in  = req_frame_texture;
               rq_min_in  = req_frame_delay_min;
               rq_max_in  = req_frame_delay_max;
               rq_rnd_in  = req_random_value;
               state_in   = S_EXEC;
            end
         end

         S_EXEC: begin
            res_tex_in   = '0;
            res_nof_in   = 1'b0;
            res_lerr_in  = 1'b0;
            need_draw_in = 1'b0;
            state_in     = S_DONE;
            unique case (rq_type_ff)
               REQ_LOAD: begin
                  if ((rq_min_ff == '0) || table_full) begin
                     res_lerr_in = 1'b1;
                  end else begin
                     ram_wr_en = 1'b1;
                     loaded_in = loaded_ff + 1'b1;
                  end
               end
               REQ_TICK: begin
                  if (loaded_ff == '0) begin
                     res_nof_in = 1'b1;
                  end else begin
                     ram_rd_en = 1'b1;
                     state_in  = S_READ;
                     if (!finished_ff) begin
                        timer_in = step ? '0 : timer_inc;
                        if (step && wrap && (loop_count_ff != '0)) begin
                           loops_in    = loops_inc;
                           finished_in = fin_now;
                        end
                        // A step that ends the last loop keeps the frame.
                        if (step && !fin_now) begin
                           ptr_in       = ptr_next;
                           ram_rd_addr  = ptr_next;
                           need_draw_in = 1'b1;
                        end
                     end
                  end
               end
               REQ_RESTART: begin
                  timer_in    = '0;
                  loops_in    = '0;
                  ptr_in      = '0;
                  finished_in = 1'b0;
                  if (loaded_ff == '0) begin
                     res_nof_in = 1'b1;
                  end else begin
                     ram_rd_en    = 1'b1;
                     ram_rd_addr  = '0;
                     need_draw_in = 1'b1;
                     state_in     = S_READ;
                  end
               end
               default: begin
                  // No-op request: nothing changes.
               end
            endcase
         end

         S_READ: begin
            res_tex_in = (rq_type_ff == REQ_TICK) ? ram_rd_data.texture : '0;
            state_in   = S_DONE;
            if (need_draw_ff) begin
               if (ram_rd_data.dmin >= ram_rd_data.dmax) begin
                  delay_in = fit_delay({1'b0, ram_rd_data.dmin});
               end else begin
                  div_lo_in  = ram_rd_data.dmin;
                  div_den_in = {1'b0, ram_rd_data.dmax} - {1'b0, ram_rd_data.dmin} + 1'b1;
                  div_rem_in = '0;
                  div_cnt_in = '0;
                  state_in   = S_DIV;
               end
            end
         end

         S_DIV: begin
            div_rem_in = div_next;
            rq_rnd_in  = rq_rnd_ff << 1;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIVC_W'(RND_W - 1)) begin
               delay_in = fit_delay({1'b0, div_lo_ff} + div_next);
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_tex_in   = res_tex_ff;
               rsp_nof_in   = res_nof_ff;
               rsp_done_in  = finished_ff;
               rsp_lerr_in  = res_lerr_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         loop_count_ff <= '0;
         loaded_ff     <= '0;
         ptr_ff        <= '0;
         timer_ff      <= '0;
         delay_ff      <= '0;
         loops_ff      <= '0;
         finished_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         loop_count_ff <= loop_count_in;
         loaded_ff     <= loaded_in;
         ptr_ff        <= ptr_in;
         timer_ff      <= timer_in;
         delay_ff      <= delay_in;
         loops_ff      <= loops_in;
         finished_ff   <= finished_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      rq_type_ff   <= rq_type_in;
      rq_tex_ff    <= rq_tex_in;
      rq_min_ff    <= rq_min_in;
      rq_max_ff    <= rq_max_in;
      rq_rnd_ff    <= rq_rnd_in;
      need_draw_ff <= need_draw_in;
      res_tex_ff   <= res_tex_in;
      res_nof_ff   <= res_nof_in;
      res_lerr_ff  <= res_lerr_in;
      div_rem_ff   <= div_rem_in;
      div_den_ff   <= div_den_in;
      div_lo_ff    <= div_lo_in;
      div_cnt_ff   <= div_cnt_in;
      rsp_tex_ff   <= rsp_tex_in;
      rsp_nof_ff   <= rsp_nof_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_lerr_ff  <= rsp_lerr_in;
   end

   // A new request beat is taken only between items and never during reset;
   // a pending response beat does not hold the next request back.
   assign req_ready       = (state_ff == S_IDLE) && !reset;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_texture_out = rsp_tex_ff;
   assign rsp_no_frames   = rsp_nof_ff;
   assign rsp_done_res    = rsp_done_ff;
   assign rsp_load_error  = rsp_lerr_ff;

endmodule

// ===== rtl/fas_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module fas_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== bench/tb_frame_animation_sequencer.sv =====
// ----------------------------------------------------------------------------
// Frame animation sequencer testbench
// Drives load, tick, restart and no-op commands into the sequencer and checks
// every response beat against an in-bench prediction of the frame table,
// hold timer, loop counter and sticky done flag, across several loop counts
// and several patterns of sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_frame_animation_sequencer
   import fas_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_SLOTS   = 16;
   localparam int SETTLE_CYCLES = 30;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SHOWN_FAULTS  = 10;

   // One command beat as it travels on the request channel.
   typedef struct packed {
      logic [1:0]        kind;
      logic [TEX_W-1:0]  tex;
      logic [HOLD_W-1:0] dmin;
      logic [HOLD_W-1:0] dmax;
      logic [RND_W-1:0]  rnd;
   } seq_cmd_type;

   // One response beat.
   typedef struct packed {
      logic [TEX_W-1:0] texture;
      logic             no_frames;
      logic             done;
      logic             load_error;
   } seq_rsp_type;

   // All block inputs start at known values.
   logic                clock;
   logic                reset               = 1'b1;
   logic                req_valid           = 1'b0;
   logic                req_ready;
   logic [1:0]          req_type            = REQ_NOP;
   logic [TEX_W-1:0]    req_frame_texture   = '0;
   logic [HOLD_W-1:0]   req_frame_delay_min = '0;
   logic [HOLD_W-1:0]   req_frame_delay_max = '0;
   logic [RND_W-1:0]    req_random_value    = '0;
   logic                rsp_valid;
   logic                rsp_ready           = 1'b0;
   logic [TEX_W-1:0]    rsp_texture_out;
   logic                rsp_no_frames;
   logic                rsp_done_res;
   logic                rsp_load_error;
   logic                csr_wr_en           = 1'b0;
   logic [LOOP_W-1:0]   csr_wr_data         = '0;

   frame_animation_sequencer #(
      .MAX_FRAMES (FRAME_SLOTS),
      .DELAY_BITS (HOLD_W)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_frame_texture   (req_frame_texture),
      .req_frame_delay_min (req_frame_delay_min),
      .req_frame_delay_max (req_frame_delay_max),
      .req_random_value    (req_random_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_texture_out     (rsp_texture_out),
      .rsp_no_frames       (rsp_no_frames),
      .rsp_done_res        (rsp_done_res),
      .rsp_load_error      (rsp_load_error),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   // Commands waiting to be driven, and responses predicted but not yet seen.
   seq_cmd_type cmd_backlog[$];
   seq_rsp_type predicted_rsps[$];

   // Handshake bookkeeping shared by the driver, the monitor and the stimulus.
   bit req_beat_seen = 1'b0;
   int cmds_issued   = 0;
   int rsps_seen     = 0;
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_left = 0;
   int frames_offered = 0;
   int cycle_count   = 0;

   // Run statistics for the closing summary.
   int fault_count   = 0;
   int load_count    = 0;
   int tick_count    = 0;
   int restart_count = 0;
   int nop_count     = 0;
   int rejected_hits = 0;
   int done_hits     = 0;
   int empty_hits    = 0;

   // Predicted sequencer state. Only entries below frames_loaded are read.
   logic [TEX_W-1:0]  tbl_tex [FRAME_SLOTS];
   logic [HOLD_W-1:0] tbl_min [FRAME_SLOTS];
   logic [HOLD_W-1:0] tbl_max [FRAME_SLOTS];
   int                frames_loaded = 0;
   int                frame_ptr     = 0;
   logic [HOLD_W-1:0] hold_timer    = '0;
   logic [HOLD_W-1:0] cur_delay     = '0;
   logic [7:0]        loops_done    = '0;
   logic [LOOP_W-1:0] loop_limit    = '0;
   bit                finished      = 1'b0;

   // A new hold time is the frame's minimum plus the random value folded into
   // the span up to its maximum; a maximum that is not above the minimum means
   // the minimum alone.
   function automatic logic [HOLD_W-1:0] pick_hold(input int idx, input logic [RND_W-1:0] rnd);
      int unsigned lo;
      int unsigned hi;
      lo = tbl_min[idx];
      hi = tbl_max[idx];
      if (lo >= hi) begin
         return HOLD_W'(lo);
      end
      return HOLD_W'(lo + rnd % (hi - lo + 1));
   endfunction

   // Applies one accepted command to the predicted state and returns the
   // response beat the sequencer owes for it.
   function automatic seq_rsp_type advance_sequence(input seq_cmd_type cmd);
      seq_rsp_type r;
      int          nxt;
      r = '0;
      case (cmd.kind)
         REQ_LOAD: begin
            if (cmd.dmin == 0 || frames_loaded >= FRAME_SLOTS) begin
               r.load_error = 1'b1;
            end else begin
               tbl_tex[frames_loaded] = cmd.tex;
               tbl_min[frames_loaded] = cmd.dmin;
               tbl_max[frames_loaded] = cmd.dmax;
               frames_loaded++;
            end
         end
         REQ_TICK: begin
            if (frames_loaded == 0) begin
               r.no_frames = 1'b1;
            end else begin
               if (!finished) begin
                  if (hold_timer != '1) begin
                     hold_timer++;
                  end
                  if (hold_timer >= cur_delay) begin
                     nxt = frame_ptr + 1;
                     hold_timer = '0;
                     if (nxt >= frames_loaded) begin
                        // A wrap counts a loop only when a limit is set.
                        if (loop_limit != 0) begin
                           if (loops_done != 8'hFF) begin
                              loops_done++;
                           end
                           if (loops_done >= loop_limit) begin
                              finished = 1'b1;
                           end
                        end
                        nxt = 0;
                     end
                     // Once done, the last frame is held and no delay drawn.
                     if (!finished) begin
                        frame_ptr = nxt;
                        cur_delay = pick_hold(frame_ptr, cmd.rnd);
                     end
                  end
               end
               r.texture = tbl_tex[frame_ptr];
            end
         end
         REQ_RESTART: begin
            hold_timer = '0;
            loops_done = '0;
            frame_ptr  = 0;
            finished   = 1'b0;
            if (frames_loaded == 0) begin
               r.no_frames = 1'b1;
            end else begin
               cur_delay = pick_hold(0, cmd.rnd);
            end
         end
         default: begin
         end
      endcase
      r.done = finished;
      return r;
   endfunction

   // Free-running clock, 8 ns period.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: a run that stops making progress ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d of %0d responses seen",
                  cycle_count, rsps_seen, cmds_issued);
         $display("tb: failure");
         $finish;
      end
   end

   // Request driver. Valid goes high only at a falling edge and then holds its
   // beat until the monitor has seen it accepted. Valid is assigned exactly once
   // per edge, so a back-to-back beat never lowers and raises it in one step.
   always @(negedge clock) begin : request_driver
      seq_cmd_type nxt;
      logic        drive_valid;
      drive_valid = req_valid;
      if (req_beat_seen) begin
         drive_valid   = 1'b0;
         req_beat_seen = 1'b0;
      end
      if (!reset && !drive_valid && cmd_backlog.size() > 0 &&
          $urandom_range(99) >= req_idle_pct) begin
         nxt = cmd_backlog.pop_front();
         drive_valid         = 1'b1;
         req_type            <= nxt.kind;
         req_frame_texture   <= nxt.tex;
         req_frame_delay_min <= nxt.dmin;
         req_frame_delay_max <= nxt.dmax;
         req_random_value    <= nxt.rnd;
      end
      req_valid <= drive_valid;
   end

   // Response acceptor. A long hold-off, when requested, keeps ready low until
   // its counter runs out; otherwise ready stalls at the phase's rate.
   always @(negedge clock) begin : response_acceptor
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Monitor. Every request beat updates the prediction; every response beat
   // is checked against the oldest predicted response.
   always @(posedge clock) begin : beat_monitor
      seq_cmd_type cmd;
      seq_rsp_type got;
      seq_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_beat_seen = 1'b1;
            cmd.kind = req_type;
            cmd.tex  = req_frame_texture;
            cmd.dmin = req_frame_delay_min;
            cmd.dmax = req_frame_delay_max;
            cmd.rnd  = req_random_value;
            case (cmd.kind)
               REQ_LOAD:    load_count++;
               REQ_TICK:    tick_count++;
               REQ_RESTART: restart_count++;
               default:     nop_count++;
            endcase
            predicted_rsps.push_back(advance_sequence(cmd));
         end
         if (rsp_valid && rsp_ready) begin
            rsps_seen++;
            got.texture    = rsp_texture_out;
            got.no_frames  = rsp_no_frames;
            got.done       = rsp_done_res;
            got.load_error = rsp_load_error;
            done_hits     += int'(got.done);
            empty_hits    += int'(got.no_frames);
            rejected_hits += int'(got.load_error);
            if (predicted_rsps.size() == 0) begin
               fault_count++;
               if (fault_count <= SHOWN_FAULTS) begin
                  $display("%0t: response beat with none predicted: tex=%h nof=%b done=%b",
                           $realtime, got.texture, got.no_frames, got.done);
               end
            end else begin
               want = predicted_rsps.pop_front();
               if (got.texture !== want.texture || got.no_frames !== want.no_frames ||
                   got.done !== want.done || got.load_error !== want.load_error) begin
                  fault_count++;
                  if (fault_count <= SHOWN_FAULTS) begin
                     $display("%0t: response %0d mismatch: expected tex=%h nof=%b done=%b lerr=%b",
                              $realtime, rsps_seen, want.texture, want.no_frames, want.done,
                              want.load_error);
                     $display("   actual tex=%h nof=%b done=%b lerr=%b",
                              got.texture, got.no_frames, got.done, got.load_error);
                  end
               end
            end
         end
      end
   end

   task automatic add_cmd(input logic [1:0] kind, input logic [TEX_W-1:0] tex,
                          input logic [HOLD_W-1:0] dmin, input logic [HOLD_W-1:0] dmax,
                          input logic [RND_W-1:0] rnd);
      seq_cmd_type c;
      c.kind = kind;
      c.tex  = tex;
      c.dmin = dmin;
      c.dmax = dmax;
      c.rnd  = rnd;
      cmd_backlog.push_back(c);
      cmds_issued++;
   endtask

   // Random commands, mostly ticks so that frames step, wrap and finish. Until
   // the table is full, loads carry short hold times that keep loops reachable;
   // after that, loads carry arbitrary fields and are all rejected.
   task automatic add_random_cmds(input int count);
      int                pick;
      logic [HOLD_W-1:0] lo;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 72) begin
            add_cmd(REQ_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         end else if (pick < 84) begin
            if (frames_offered < FRAME_SLOTS) begin
               lo = HOLD_W'($urandom_range(3, 1));
               add_cmd(REQ_LOAD, 16'($urandom), lo,
                       lo - HOLD_W'(1) + HOLD_W'($urandom_range(3, 0)), 16'($urandom));
               frames_offered++;
            end else begin
               add_cmd(REQ_LOAD, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            end
         end else if (pick < 88) begin
            add_cmd(REQ_RESTART, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         end else if (pick < 92) begin
            add_cmd(REQ_NOP, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         end else begin
            // Broken load: a zero minimum is always rejected.
            add_cmd(REQ_LOAD, 16'($urandom), '0, 16'($urandom), 16'($urandom));
         end
      end
   endtask

   // Waits until every command has produced its response, then lets the
   // block settle for a full worst-case item time.
   task automatic wait_for_quiet();
      do @(negedge clock); while (rsps_seen < cmds_issued);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // The loop count register only changes while nothing is in flight.
   task automatic write_loop_count(input logic [LOOP_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      loop_limit   = value;
   endtask

   task automatic run_phase(input logic [LOOP_W-1:0] loops, input int idle_pct,
                            input int stall_pct, input int hold, input int count);
      write_loop_count(loops);
      @(posedge clock);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      rsp_hold_left = hold;
      add_random_cmds(count);
      wait_for_quiet();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, one loop before done. The table starts empty, so the
      // first tick and restart report no frames and the restart keeps the
      // zero delay; the first tick after loading then steps at once.
      write_loop_count(8'd1);
      add_cmd(REQ_TICK,    16'h0000, 16'h0000, 16'h0000, 16'h0000);
      add_cmd(REQ_RESTART, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_cmd(REQ_NOP,     16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_cmd(REQ_LOAD,    16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
      add_cmd(REQ_LOAD,    16'hFFFF, 16'h0001, 16'h0000, 16'h0000);
      add_cmd(REQ_LOAD,    16'h0000, 16'h0002, 16'h0002, 16'hFFFF);
      add_cmd(REQ_LOAD,    16'hA5A5, 16'h0001, 16'h0004, 16'h5A5A);
      frames_offered = 3;
      add_cmd(REQ_TICK,    16'h0000, 16'h0000, 16'h0000, 16'h0003);
      add_cmd(REQ_TICK,    16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      add_cmd(REQ_TICK,    16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      add_cmd(REQ_RESTART, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      repeat (9) begin
         add_cmd(REQ_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      end
      // The loop limit has been reached by now; ticks keep the held frame.
      add_cmd(REQ_NOP,     16'h0000, 16'h0000, 16'h0000, 16'h0000);
      add_cmd(REQ_RESTART, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      add_cmd(REQ_TICK,    16'h0000, 16'h0000, 16'h0000, 16'h0000);
      wait_for_quiet();

      // Random phases: loop limits from forever to the maximum, under
      // different gap and stall patterns. The last phase opens with a long
      // receiver hold-off so that the block fills up and stalls its input.
      run_phase(8'd0,   0,  0,   0, 100);
      run_phase(8'd255, 67, 0,   0, 100);
      run_phase(8'd1,   0,  67,  0, 100);
      run_phase(8'd2,   13, 13,  0, 100);
      run_phase(8'd3,   0,  0, 400, 100);

      if (predicted_rsps.size() != 0) begin
         $display("%0d predicted responses never arrived", predicted_rsps.size());
         fault_count += predicted_rsps.size();
      end
      $display("Covered %0d commands: %0d loads (%0d rejected), %0d ticks, %0d restarts,",
               cmds_issued, load_count, rejected_hits, tick_count, restart_count);
      $display("%0d no-ops; responses with done set: %0d, with an empty table: %0d.",
               nop_count, done_hits, empty_hits);
      if (fault_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
